// ===== rtl/tdc_pkg.sv =====
// Package for the trajectory deviation check: request kinds, controller states
// and the control structs passed between the top level and the error pipeline.
// Depends on nothing.
`default_nettype none

package tdc_pkg;

	localparam int COORD_W    = 16;
	localparam int POINT_W    = 2 * COORD_W;
	localparam int MIN_STROKE = 2;
	localparam int MIN_REF    = 4;
	// Squared errors wrap at this many bits, as the checked arithmetic does.
	localparam int SQ_WRAP_W  = 64;

	typedef enum logic [2:0] {
		KIND_PUSH_STROKE  = 3'd0,
		KIND_PUSH_REF     = 3'd1,
		KIND_CLEAR_STROKE = 3'd2,
		KIND_CLEAR_REF    = 3'd3,
		KIND_CHECK        = 3'd4
	} tdc_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} tdc_state_t;

	typedef struct packed {
		logic valid;
		logic last;
	} tdc_pipe_ctl_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} tdc_pipe_res_t;

endpackage

`default_nettype wire

// ===== rtl/trajectory_deviation_check.sv =====
// Top level of the trajectory deviation check: stroke ring and reference memories,
// request decoding, check sequencer and result register.
// Depends on tdc_pkg, tdc_divider and tdc_error_pipe.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  kind, x_coord, y_coord
//   out      output     out_valid/ out_stall deviating
//   cfg      input      cfg_valid/ cfg_ready threshold
//
// Pushes and clears are accepted while idle. A check is accepted, then runs the divider,
// reads one stored stroke point per cycle from the memories, then drains the error
// pipeline and loads the result; a disabled check skips the divider and the walk.
// Reset clears the counts, head and threshold; the memories are not cleared.
// in_stall is high while a check runs and while its result waits for the output register.
`default_nettype none

module trajectory_deviation_check
	import tdc_pkg::*;
#(
	parameter int STROKE_CAPACITY    = 4096,
	parameter int REFERENCE_CAPACITY = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         kind,
	input  wire logic [COORD_W-1:0] x_coord,
	input  wire logic [COORD_W-1:0] y_coord,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    deviating,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COORD_W-1:0] threshold
);

	localparam int SA_W = $clog2(STROKE_CAPACITY);
	localparam int SC_W = $clog2(STROKE_CAPACITY + 1);
	localparam int RA_W = $clog2(REFERENCE_CAPACITY);
	localparam int RC_W = $clog2(REFERENCE_CAPACITY + 1);
	localparam int T_W  = COORD_W + SA_W;
	localparam int RH_W = 2 * T_W;

	tdc_state_t         state_q, state_d;
	logic [COORD_W-1:0] threshold_q;
	logic [SA_W-1:0]    stroke_head_q;
	logic [SC_W-1:0]    stroke_count_q;
	logic [RC_W-1:0]    ref_count_q;
	logic               out_valid_q;
	logic               deviating_q;
	logic               result_q;
	logic               hit_acc_q;
	tdc_pipe_ctl_t      ctl_s1;
	logic [SA_W-1:0]    r_s1;

	logic [SA_W-1:0]    d_q;
	logic [RA_W-1:0]    nrm1_q;
	logic [SA_W-1:0]    idx_q;
	logic [SA_W-1:0]    i_q;
	logic [RA_W-1:0]    b_q;
	logic [SA_W-1:0]    r_q;
	logic [T_W-1:0]     t_q;
	logic [RH_W-1:0]    rhs_q;

	logic [POINT_W-1:0] stroke_mem [STROKE_CAPACITY];
	logic [POINT_W-1:0] ref_mem [REFERENCE_CAPACITY];
	logic [POINT_W-1:0] stroke_rd;
	logic [POINT_W-1:0] lo_rd;
	logic [POINT_W-1:0] hi_rd;

	logic               in_accept;
	tdc_kind_t          kind_c;
	logic [POINT_W-1:0] point_c;
	logic               check_enabled;
	logic               stroke_full;
	logic [SA_W:0]      wsum;
	logic [SA_W:0]      wsum_wrap;
	logic [SA_W-1:0]    stroke_wr_addr;
	logic               stroke_wr_en;
	logic               ref_wr_en;
	logic               walk_en;
	logic               walk_last;
	logic               div_start;
	logic               out_load;
	logic [RA_W-1:0]    n_c;
	logic [SA_W:0]      r_sum;
	logic               r_ge;
	logic [SA_W:0]      r_next;
	logic [RA_W:0]      b_next;
	logic [SA_W-1:0]    idx_next;
	logic               div_done;
	logic [RA_W-1:0]    step_q;
	logic [SA_W-1:0]    step_r;
	tdc_pipe_ctl_t      walk_ctl;
	tdc_pipe_res_t      pipe_res;

	assign kind_c        = tdc_kind_t'(kind);
	assign point_c       = {y_coord, x_coord};
	assign in_accept     = in_valid && !in_stall;
	assign check_enabled = (threshold_q != '0) && (stroke_count_q >= SC_W'(MIN_STROKE))
		&& (ref_count_q >= RC_W'(MIN_REF));
	assign stroke_full   = stroke_count_q == SC_W'(STROKE_CAPACITY);

	assign wsum      = (SA_W + 1)'(stroke_head_q) + (SA_W + 1)'(stroke_count_q);
	assign wsum_wrap = (wsum >= (SA_W + 1)'(STROKE_CAPACITY))
		? wsum - (SA_W + 1)'(STROKE_CAPACITY) : wsum;
	assign stroke_wr_addr = stroke_full ? stroke_head_q : wsum_wrap[SA_W-1:0];
	assign stroke_wr_en   = in_accept && (kind_c == KIND_PUSH_STROKE);
	assign ref_wr_en      = in_accept && (kind_c == KIND_PUSH_REF)
		&& (ref_count_q < RC_W'(REFERENCE_CAPACITY));

	assign walk_last = i_q == d_q;
	assign n_c       = (b_q == nrm1_q) ? b_q : b_q + 1'b1;
	assign r_sum     = {1'b0, r_q} + {1'b0, step_r};
	assign r_ge      = r_sum >= {1'b0, d_q};
	assign r_next    = r_ge ? r_sum - {1'b0, d_q} : r_sum;
	assign b_next    = {1'b0, b_q} + {1'b0, step_q} + (RA_W + 1)'(r_ge);
	assign idx_next  = (idx_q == SA_W'(STROKE_CAPACITY - 1)) ? '0 : idx_q + 1'b1;

	assign walk_ctl.valid = walk_en;
	assign walk_ctl.last  = walk_en && walk_last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && (kind_c == KIND_CHECK)) begin
					state_d = check_enabled ? ST_DIV : ST_FINISH;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_res.valid && pipe_res.last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = state_q != ST_IDLE;
		walk_en   = state_q == ST_WALK;
		div_start = (state_q == ST_IDLE) && in_accept && (kind_c == KIND_CHECK)
			&& check_enabled;
		out_load  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			threshold_q    <= '0;
			stroke_head_q  <= '0;
			stroke_count_q <= '0;
			ref_count_q    <= '0;
			out_valid_q    <= 1'b0;
			ctl_s1         <= '0;
		end else begin
			state_q <= state_d;
			ctl_s1  <= walk_ctl;
			if (cfg_valid && cfg_ready) begin
				threshold_q <= threshold;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_accept) begin
				case (kind_c)
					KIND_PUSH_STROKE: begin
						if (stroke_full) begin
							stroke_head_q <= (stroke_head_q == SA_W'(STROKE_CAPACITY - 1))
								? '0 : stroke_head_q + 1'b1;
						end else begin
							stroke_count_q <= stroke_count_q + 1'b1;
						end
					end
					KIND_PUSH_REF: begin
						if (ref_wr_en) begin
							ref_count_q <= ref_count_q + 1'b1;
						end
					end
					KIND_CLEAR_STROKE: begin
						stroke_head_q  <= '0;
						stroke_count_q <= '0;
					end
					KIND_CLEAR_REF: begin
						ref_count_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		t_q   <= threshold_q * d_q;
		rhs_q <= t_q * t_q;
		r_s1  <= r_q;
		if (pipe_res.valid) begin
			hit_acc_q <= hit_acc_q | pipe_res.hit;
		end
		if (in_accept && (kind_c == KIND_CHECK)) begin
			d_q       <= SA_W'(stroke_count_q - 1'b1);
			nrm1_q    <= RA_W'(ref_count_q - 1'b1);
			idx_q     <= stroke_head_q;
			i_q       <= '0;
			b_q       <= '0;
			r_q       <= '0;
			hit_acc_q <= 1'b0;
			result_q  <= 1'b0;
		end
		if (walk_en) begin
			idx_q <= idx_next;
			i_q   <= i_q + 1'b1;
			b_q   <= b_next[RA_W-1:0];
			r_q   <= r_next[SA_W-1:0];
		end
		if ((state_q == ST_DRAIN) && pipe_res.valid && pipe_res.last) begin
			result_q <= hit_acc_q | pipe_res.hit;
		end
		if (out_load) begin
			deviating_q <= result_q;
		end
	end

	always_ff @(posedge clk) begin
		if (stroke_wr_en) begin
			stroke_mem[stroke_wr_addr] <= point_c;
		end
		if (walk_en) begin
			stroke_rd <= stroke_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ref_wr_en) begin
			ref_mem[ref_count_q[RA_W-1:0]] <= point_c;
		end
		if (walk_en) begin
			lo_rd <= ref_mem[b_q];
			hi_rd <= ref_mem[n_c];
		end
	end

	tdc_divider #(
		.NW(RA_W),
		.DW(SA_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (RA_W'(ref_count_q - 1'b1)),
		.divisor  (SA_W'(stroke_count_q - 1'b1)),
		.done     (div_done),
		.quotient (step_q),
		.remainder(step_r)
	);

	tdc_error_pipe #(
		.SA_W(SA_W)
	) u_error_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_s1),
		.stroke_pt(stroke_rd),
		.lo_pt    (lo_rd),
		.hi_pt    (hi_rd),
		.r_in     (r_s1),
		.d_in     (d_q),
		.rhs_in   (rhs_q),
		.res      (pipe_res)
	);

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign deviating = deviating_q;

endmodule

`default_nettype wire

// ===== rtl/tdc_divider.sv =====
// Restoring divider for the trajectory deviation check, one quotient bit a cycle.
// Gives quotient and remainder of the reference step over the stroke span.
// Depends on nothing.
`default_nettype none

module tdc_divider #(
	parameter int NW = 12,
	parameter int DW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient,
	output logic [DW-1:0]      remainder
);

	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dsr_q;
	logic [DW:0]      shifted;
	logic             fits;
	logic [DW:0]      diff;

	assign shifted = {rem_q, num_q[NW-1]};
	assign fits    = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/tdc_error_pipe.sv =====
// Error pipeline for the trajectory deviation check: scaled interpolation error
// per axis, its square and the comparison against the scaled threshold squared.
// Depends on tdc_pkg.
`default_nettype none

module tdc_error_pipe
	import tdc_pkg::*;
#(
	parameter int SA_W = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tdc_pipe_ctl_t                 ctl_in,
	input  wire logic [POINT_W-1:0]            stroke_pt,
	input  wire logic [POINT_W-1:0]            lo_pt,
	input  wire logic [POINT_W-1:0]            hi_pt,
	input  wire logic [SA_W-1:0]               r_in,
	input  wire logic [SA_W-1:0]               d_in,
	input  wire logic [2*(COORD_W+SA_W)-1:0]   rhs_in,
	output tdc_pipe_res_t                      res
);

	localparam int DIFF_W    = COORD_W + 1;
	localparam int PW        = DIFF_W + SA_W + 1;
	localparam int EW        = COORD_W + 1 + SA_W;
	localparam int FULL_SQ_W = 2 * EW;
	localparam int SQ_W      = (FULL_SQ_W > SQ_WRAP_W) ? SQ_WRAP_W : FULL_SQ_W;

	tdc_pipe_ctl_t        ctl_s2, ctl_s3, ctl_s4;
	tdc_pipe_res_t        res_q;
	logic signed [PW-1:0] p1_s2 [2];
	logic signed [PW-1:0] p2_s2 [2];
	logic [EW-1:0]        ae_s3 [2];
	logic [SQ_W-1:0]      sq_s4 [2];
	logic [SQ_W:0]        sum_c;

	for (genvar ax = 0; ax < 2; ax++) begin : g_axis
		logic [COORD_W-1:0]      a_c, lo_c, hi_c;
		logic signed [DIFF_W-1:0] dal_c, dhl_c;
		logic signed [PW-1:0]    p1_c, p2_c;
		logic signed [PW:0]      e_c;
		logic [PW:0]             mag_c;
		logic [FULL_SQ_W-1:0]    sq_c;

		assign a_c   = stroke_pt[ax*COORD_W +: COORD_W];
		assign lo_c  = lo_pt[ax*COORD_W +: COORD_W];
		assign hi_c  = hi_pt[ax*COORD_W +: COORD_W];
		assign dal_c = $signed({1'b0, a_c}) - $signed({1'b0, lo_c});
		assign dhl_c = $signed({1'b0, hi_c}) - $signed({1'b0, lo_c});
		assign p1_c  = dal_c * $signed({1'b0, d_in});
		assign p2_c  = dhl_c * $signed({1'b0, r_in});
		assign e_c   = p1_s2[ax] - p2_s2[ax];
		assign mag_c = e_c[PW] ? $unsigned(-e_c) : $unsigned(e_c);
		assign sq_c  = ae_s3[ax] * ae_s3[ax];

		always_ff @(posedge clk) begin
			p1_s2[ax] <= p1_c;
			p2_s2[ax] <= p2_c;
			ae_s3[ax] <= mag_c[EW-1:0];
			sq_s4[ax] <= sq_c[SQ_W-1:0];
		end
	end

	assign sum_c = {1'b0, sq_s4[0]} + {1'b0, sq_s4[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			res_q  <= '0;
		end else begin
			ctl_s2      <= ctl_in;
			ctl_s3      <= ctl_s2;
			ctl_s4      <= ctl_s3;
			res_q.valid <= ctl_s4.valid;
			res_q.last  <= ctl_s4.last;
			res_q.hit   <= ctl_s4.valid && (sum_c > (SQ_W + 1)'(rhs_in));
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire
